// ===== sv/gha_pkg.sv =====
// Package for the generational handle allocator.
// Holds the operation and status codes shared by the sequencer and the top level.
// No dependencies.
`default_nettype none

package gha_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam func_t F_ALLOC    = 2'd0;
  localparam func_t F_RELEASE  = 2'd1;
  localparam func_t F_VALIDATE = 2'd2;
  localparam func_t F_FIND     = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_INVALID   = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ===== sv/gha_ram.sv =====
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
`default_nettype none

module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/gha_ctrl.sv =====
// Sequencer of the handle allocator: free list, counters, handle check and name scan.
// Drives the name RAM and the version/next-free RAM; depends on gha_pkg.
`default_nettype none

module gha_ctrl #(
  parameter int CAPACITY     = 1024,
  parameter int VERSION_BITS = 16,
  parameter int NAME_BITS    = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire gha_pkg::func_t              in_func,
  input  wire logic [$clog2(CAPACITY)-1:0] in_handle_index,
  input  wire logic [VERSION_BITS-1:0]     in_handle_version,
  input  wire logic [NAME_BITS-1:0]        in_name_key,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output gha_pkg::status_t                 out_status,
  output logic [$clog2(CAPACITY)-1:0]      out_index,
  output logic [VERSION_BITS-1:0]          out_version,
  output logic                             name_we,
  output logic [$clog2(CAPACITY)-1:0]      name_waddr,
  output logic [NAME_BITS-1:0]             name_wdata,
  output logic [$clog2(CAPACITY)-1:0]      name_raddr,
  input  wire logic [NAME_BITS-1:0]        name_rdata,
  output logic                             meta_we,
  output logic [$clog2(CAPACITY)-1:0]      meta_waddr,
  output logic [VERSION_BITS+$clog2(CAPACITY)-1:0] meta_wdata,
  output logic [$clog2(CAPACITY)-1:0]      meta_raddr,
  input  wire logic [VERSION_BITS+$clog2(CAPACITY)-1:0] meta_rdata
);

  import gha_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0]        CAP_C   = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]        CNT_ONE = CNT_W'(1);
  localparam logic [VERSION_BITS-1:0] VER_ONE = VERSION_BITS'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FVER = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]              state_r, state_nxt;
  func_t                   func_r, func_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [VERSION_BITS-1:0] ver_r, ver_nxt;
  logic [NAME_BITS-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]        used_r, used_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        flen_r, flen_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic [IDX_W-1:0]        res_index_r, res_index_nxt;
  logic [VERSION_BITS-1:0] res_version_r, res_version_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [IDX_W-1:0]        out_index_r, out_index_nxt;
  logic [VERSION_BITS-1:0] out_version_r, out_version_nxt;

  logic                    fin;
  status_t                 fin_status;
  logic [IDX_W-1:0]        fin_index;
  logic [VERSION_BITS-1:0] fin_version;

  logic [VERSION_BITS-1:0] meta_ver;
  logic [IDX_W-1:0]        meta_next;
  logic [VERSION_BITS-1:0] ver_inc;
  logic [VERSION_BITS-1:0] ver_bump;
  logic                    handle_ok;
  logic                    out_free;
  logic [CNT_W-1:0]        scan_inc;

  assign meta_ver  = meta_rdata[VERSION_BITS+IDX_W-1:IDX_W];
  assign meta_next = meta_rdata[IDX_W-1:0];
  assign ver_inc   = meta_ver + VER_ONE;
  assign ver_bump  = (ver_inc == '0) ? VER_ONE : ver_inc;
  assign scan_inc  = scan_r + CNT_ONE;
  assign out_free  = !out_valid_r || !out_stall;

  // The stored version is trusted only for slots below the used count.
  assign handle_ok = (idx_r != '0) && (CNT_W'(idx_r) < used_r) &&
                     (ver_r != '0) && (meta_ver == ver_r);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    idx_nxt         = idx_r;
    ver_nxt         = ver_r;
    key_nxt         = key_r;
    used_nxt        = used_r;
    head_nxt        = head_r;
    flen_nxt        = flen_r;
    scan_nxt        = scan_r;
    res_status_nxt  = res_status_r;
    res_index_nxt   = res_index_r;
    res_version_nxt = res_version_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    out_version_nxt = out_version_r;
    name_we         = 1'b0;
    name_waddr      = '0;
    name_wdata      = '0;
    name_raddr      = scan_r[IDX_W-1:0];
    meta_we         = 1'b0;
    meta_waddr      = '0;
    meta_wdata      = '0;
    meta_raddr      = head_r;
    fin             = 1'b0;
    fin_status      = ST_OK;
    fin_index       = '0;
    fin_version     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          idx_nxt    = in_handle_index;
          ver_nxt    = in_handle_version;
          key_nxt    = in_name_key;
          meta_raddr = (in_func == F_ALLOC) ? head_r : in_handle_index;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          F_ALLOC: begin
            if (flen_r != '0) begin
              // Pop the free list; the slot keeps the version set on release.
              name_we     = 1'b1;
              name_waddr  = head_r;
              name_wdata  = key_r;
              head_nxt    = meta_next;
              flen_nxt    = flen_r - CNT_ONE;
              fin         = 1'b1;
              fin_index   = head_r;
              fin_version = meta_ver;
            end else if (used_r >= CAP_C) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              name_we     = 1'b1;
              name_waddr  = used_r[IDX_W-1:0];
              name_wdata  = key_r;
              meta_we     = 1'b1;
              meta_waddr  = used_r[IDX_W-1:0];
              meta_wdata  = {VER_ONE, {IDX_W{1'b0}}};
              used_nxt    = used_r + CNT_ONE;
              fin         = 1'b1;
              fin_index   = used_r[IDX_W-1:0];
              fin_version = VER_ONE;
            end
          end
          F_RELEASE: begin
            fin = 1'b1;
            if (handle_ok) begin
              name_we    = 1'b1;
              name_waddr = idx_r;
              name_wdata = '0;
              meta_we    = 1'b1;
              meta_waddr = idx_r;
              meta_wdata = {ver_bump, head_r};
              head_nxt   = idx_r;
              if (flen_r < CAP_C) begin
                flen_nxt = flen_r + CNT_ONE;
              end
            end else begin
              fin_status = ST_INVALID;
            end
          end
          F_VALIDATE: begin
            fin = 1'b1;
            if (handle_ok) begin
              fin_index   = idx_r;
              fin_version = ver_r;
            end else begin
              fin_status = ST_INVALID;
            end
          end
          default: begin
            // Slot 0 never holds a name, so the scan starts at slot 1.
            if ((key_r == '0) || (used_r <= CNT_ONE)) begin
              fin        = 1'b1;
              fin_status = ST_NOT_FOUND;
            end else begin
              scan_nxt   = CNT_ONE;
              name_raddr = CNT_ONE[IDX_W-1:0];
              state_nxt  = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        // The name read back belongs to the slot issued in the previous cycle.
        if (name_rdata == key_r) begin
          meta_raddr = scan_r[IDX_W-1:0];
          state_nxt  = S_FVER;
        end else if (scan_inc >= used_r) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
        end else begin
          scan_nxt   = scan_inc;
          name_raddr = scan_inc[IDX_W-1:0];
        end
      end
      S_FVER: begin
        fin         = 1'b1;
        fin_index   = scan_r[IDX_W-1:0];
        fin_version = meta_ver;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_index_nxt   = res_index_r;
          out_version_nxt = res_version_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = fin_status;
        out_index_nxt   = fin_index;
        out_version_nxt = fin_version;
        state_nxt       = S_IDLE;
      end else begin
        res_status_nxt  = fin_status;
        res_index_nxt   = fin_index;
        res_version_nxt = fin_version;
        state_nxt       = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= CNT_ONE;
      head_r      <= '0;
      flen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      flen_r      <= flen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    idx_r         <= idx_nxt;
    ver_r         <= ver_nxt;
    key_r         <= key_nxt;
    scan_r        <= scan_nxt;
    res_status_r  <= res_status_nxt;
    res_index_r   <= res_index_nxt;
    res_version_r <= res_version_nxt;
    out_status_r  <= out_status_nxt;
    out_index_r   <= out_index_nxt;
    out_version_r <= out_version_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_index   = out_index_r;
  assign out_version = out_version_r;

endmodule

`default_nettype wire

// ===== sv/generational_handle_allocator.sv =====
// Generational handle allocator: allocate, release and validate each read one word of the
// version/next-free RAM, and a new item is taken only after the last result has entered the
// output register. Find walks the name RAM one slot per cycle, then reads the version of the
// matching slot. A result that meets a stalled output holds the input off until it can leave.
// Reset clears the counters and free list head only; no clearing pass runs. Depends on
// gha_pkg, gha_ram and gha_ctrl.
`default_nettype none

module generational_handle_allocator #(
  parameter int CAPACITY     = 1024,
  parameter int VERSION_BITS = 16,
  parameter int NAME_BITS    = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire gha_pkg::func_t              in_func,
  input  wire logic [$clog2(CAPACITY)-1:0] in_handle_index,
  input  wire logic [VERSION_BITS-1:0]     in_handle_version,
  input  wire logic [NAME_BITS-1:0]        in_name_key,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output gha_pkg::status_t                 out_status,
  output logic [$clog2(CAPACITY)-1:0]      out_index,
  output logic [VERSION_BITS-1:0]          out_version
);

  import gha_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int META_W = VERSION_BITS + IDX_W;

  logic                 name_we;
  logic [IDX_W-1:0]     name_waddr;
  logic [NAME_BITS-1:0] name_wdata;
  logic [IDX_W-1:0]     name_raddr;
  logic [NAME_BITS-1:0] name_rdata;
  logic                 meta_we;
  logic [IDX_W-1:0]     meta_waddr;
  logic [META_W-1:0]    meta_wdata;
  logic [IDX_W-1:0]     meta_raddr;
  logic [META_W-1:0]    meta_rdata;

  gha_ctrl #(
    .CAPACITY    (CAPACITY),
    .VERSION_BITS(VERSION_BITS),
    .NAME_BITS   (NAME_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_handle_index  (in_handle_index),
    .in_handle_version(in_handle_version),
    .in_name_key      (in_name_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_index        (out_index),
    .out_version      (out_version),
    .name_we          (name_we),
    .name_waddr       (name_waddr),
    .name_wdata       (name_wdata),
    .name_raddr       (name_raddr),
    .name_rdata       (name_rdata),
    .meta_we          (meta_we),
    .meta_waddr       (meta_waddr),
    .meta_wdata       (meta_wdata),
    .meta_raddr       (meta_raddr),
    .meta_rdata       (meta_rdata)
  );

  // Name key of each slot.
  gha_ram #(
    .WIDTH(NAME_BITS),
    .DEPTH(CAPACITY)
  ) u_name_ram (
    .clk  (clk),
    .we   (name_we),
    .waddr(name_waddr),
    .wdata(name_wdata),
    .raddr(name_raddr),
    .rdata(name_rdata)
  );

  // Version and free list link of each slot, kept in one word.
  gha_ram #(
    .WIDTH(META_W),
    .DEPTH(CAPACITY)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .raddr(meta_raddr),
    .rdata(meta_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/tb_generational_handle_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator, built on gha_pkg.
// A queue-fed driver and a monitor with random idling; every result is compared with
// an in-bench prediction of the slot table, free list and version counters.

module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int CAPACITY       = 1024;
  localparam int IDX_W          = 10;
  localparam int VER_W          = 16;
  localparam int KEY_W          = 32;
  localparam int RANDOM_ITEMS   = 520;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct packed {
    func_t             func;
    logic [IDX_W-1:0]  idx;
    logic [VER_W-1:0]  ver;
    logic [KEY_W-1:0]  key;
  } handle_op_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  index;
    logic [VER_W-1:0]  version;
  } handle_result_t;

  logic             clk               = 1'b0;
  logic             rst_n             = 1'b0;
  logic             in_valid          = 1'b0;
  logic             in_stall;
  func_t            in_func           = F_ALLOC;
  logic [IDX_W-1:0] in_handle_index   = '0;
  logic [VER_W-1:0] in_handle_version = '0;
  logic [KEY_W-1:0] in_name_key       = '0;
  logic             out_valid;
  logic             out_stall         = 1'b0;
  status_t          out_status;
  logic [IDX_W-1:0] out_index;
  logic [VER_W-1:0] out_version;

  generational_handle_allocator #(
    .CAPACITY    (CAPACITY),
    .VERSION_BITS(VER_W),
    .NAME_BITS   (KEY_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_handle_index  (in_handle_index),
    .in_handle_version(in_handle_version),
    .in_name_key      (in_name_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_index        (out_index),
    .out_version      (out_version)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the slot table.
  logic [KEY_W-1:0] slot_key  [CAPACITY] = '{default: '0};
  logic [VER_W-1:0] slot_ver  [CAPACITY] = '{default: '0};
  logic [IDX_W-1:0] slot_next [CAPACITY] = '{default: '0};
  int               used_cnt  = 1;
  logic [IDX_W-1:0] free_head = '0;
  int               free_len  = 0;

  handle_op_t     op_q[$];
  handle_result_t exp_result_q[$];
  handle_op_t     cur_op;
  bit             have_item   = 1'b0;
  int             send_gap    = 0;
  int             stall_left  = 0;
  bit             quiet       = 1'b0;
  int             err_cnt     = 0;
  int             idle_cycles = 0;

  function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [VER_W-1:0] ver);
    return idx != 0 && int'(idx) < used_cnt && ver != 0 && slot_ver[idx] == ver;
  endfunction

  // Applies one item to the predicted table and returns the result it should give.
  function automatic handle_result_t apply_op(handle_op_t op);
    handle_result_t   r;
    logic [IDX_W-1:0] s;
    logic [VER_W-1:0] v;
    bit               found;
    r = '0;
    case (op.func)
      F_ALLOC: begin
        if (free_len > 0) begin
          free_len--;
          s = free_head;
          free_head = slot_next[s];
          slot_key[s] = op.key;
          r.status = ST_OK;
          r.index = s;
          r.version = slot_ver[s];
        end else if (used_cnt >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          s = used_cnt[IDX_W-1:0];
          used_cnt++;
          slot_key[s] = op.key;
          slot_ver[s] = VER_W'(1);
          r.status = ST_OK;
          r.index = s;
          r.version = VER_W'(1);
        end
      end
      F_RELEASE: begin
        if (!handle_live(op.idx, op.ver)) begin
          r.status = ST_INVALID;
        end else begin
          slot_key[op.idx] = '0;
          v = slot_ver[op.idx] + 1'b1;
          slot_ver[op.idx] = (v == '0) ? VER_W'(1) : v;
          slot_next[op.idx] = free_head;
          free_head = op.idx;
          if (free_len < CAPACITY) free_len++;
          r.status = ST_OK;
        end
      end
      F_VALIDATE: begin
        if (!handle_live(op.idx, op.ver)) begin
          r.status = ST_INVALID;
        end else begin
          r.status = ST_OK;
          r.index = op.idx;
          r.version = op.ver;
        end
      end
      default: begin
        found = 1'b0;
        r.status = ST_NOT_FOUND;
        if (op.key != 0) begin
          for (int c = 0; c < used_cnt && !found; c++) begin
            if (slot_key[c] == op.key) begin
              found = 1'b1;
              r.status = ST_OK;
              r.index = c[IDX_W-1:0];
              r.version = slot_ver[c];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_op(func_t f, logic [IDX_W-1:0] idx, logic [VER_W-1:0] ver,
                          logic [KEY_W-1:0] key);
    handle_op_t op;
    op.func = f;
    op.idx  = idx;
    op.ver  = ver;
    op.key  = key;
    while (op_q.size() >= 2) @(negedge clk);
    op_q.push_back(op);
  endtask

  // Waits until every queued item has been sent and every result has come back.
  task automatic drain();
    while (op_q.size() != 0 || have_item || exp_result_q.size() != 0) @(negedge clk);
  endtask

  function automatic int live_index();
    return (used_cnt > 1) ? $urandom_range(used_cnt - 1, 1) : 1;
  endfunction

  // Driver: holds each item for a random number of cycles, then offers it until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      have_item = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        exp_result_q.push_back(apply_op(cur_op));
        have_item = 1'b0;
      end
      if (!have_item && op_q.size() != 0) begin
        cur_op = op_q.pop_front();
        have_item = 1'b1;
        send_gap = quiet ? 0 : $urandom_range(7, 0);
      end
      if (have_item && send_gap == 0) begin
        in_valid          <= 1'b1;
        in_func           <= cur_op.func;
        in_handle_index   <= cur_op.idx;
        in_handle_version <= cur_op.ver;
        in_name_key       <= cur_op.key;
      end else begin
        in_valid <= 1'b0;
        if (have_item) send_gap--;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then stalls at random.
  always @(posedge clk) begin
    handle_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_result_q.size() == 0) begin
          $error("result with nothing expected: status %0d index %0d version %0d",
                 out_status, out_index, out_version);
          err_cnt++;
        end else begin
          want = exp_result_q.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            err_cnt++;
          end
          if (out_index !== want.index) begin
            $error("out_index: expected %0d, got %0d", want.index, out_index);
            err_cnt++;
          end
          if (out_version !== want.version) begin
            $error("out_version: expected %0d, got %0d", want.version, out_version);
            err_cnt++;
          end
        end
        stall_left = quiet ? 0 : $urandom_range(7, 0);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool [8];
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
    logic [KEY_W-1:0] key;
    int               pick;
    int               roll;

    key_pool[0] = '1;
    for (int k = 1; k < 8; k++) key_pool[k] = $urandom();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, extreme fields, double release and reuse of a freed slot.
    queue_op(F_VALIDATE, '0, '0, '0);
    queue_op(F_RELEASE, 10'd5, 16'd1, '0);
    queue_op(F_FIND, '1, '1, '0);
    queue_op(F_FIND, '0, '0, '1);
    queue_op(F_ALLOC, '1, '1, '1);
    queue_op(F_ALLOC, '0, '0, '0);
    queue_op(F_ALLOC, '0, '0, 32'h1234_5678);
    queue_op(F_FIND, '0, '0, '1);
    queue_op(F_FIND, '0, '0, '0);
    queue_op(F_VALIDATE, 10'd1, 16'd1, '1);
    queue_op(F_VALIDATE, 10'd1, '0, '0);
    queue_op(F_VALIDATE, 10'd1, '1, '0);
    queue_op(F_VALIDATE, '1, 16'd1, '0);
    queue_op(F_RELEASE, 10'd1, 16'd1, '0);
    queue_op(F_RELEASE, 10'd1, 16'd1, '0);
    queue_op(F_RELEASE, 10'd1, 16'd2, '0);
    queue_op(F_FIND, '0, '0, '1);
    queue_op(F_ALLOC, '0, '0, 32'hAAAA_AAAA);
    queue_op(F_ALLOC, '0, '0, 32'h5555_5555);
    queue_op(F_ALLOC, '0, '0, 32'h1234_5678);
    queue_op(F_VALIDATE, 10'd1, 16'd3, '0);
    queue_op(F_FIND, '0, '0, 32'hAAAA_AAAA);
    queue_op(F_FIND, '0, '0, 32'h5555_5555);
    queue_op(F_FIND, '0, '0, 32'h1234_5678);
    queue_op(F_RELEASE, 10'd3, 16'd1, '0);

    // Random: mostly handles taken from the live table, with stale and garbage ones mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 150 && n < 230);
      if (n == 300) drain();
      pick = $urandom_range(99, 0);
      roll = $urandom_range(99, 0);
      if (roll < 40) key = $urandom();
      else if (roll < 70) key = key_pool[$urandom_range(7, 0)];
      else if (roll < 80) key = '0;
      else key = slot_key[live_index()];
      roll = $urandom_range(99, 0);
      if (roll < 75) begin
        idx = IDX_W'(live_index());
        ver = slot_ver[idx];
      end else if (roll < 85) begin
        idx = IDX_W'(live_index());
        ver = $urandom_range(1, 0) ? slot_ver[idx] + 1'b1 : slot_ver[idx] - 1'b1;
      end else begin
        idx = IDX_W'($urandom_range(CAPACITY - 1, 0));
        ver = VER_W'($urandom_range(65535, 0));
      end
      if (pick < 35) queue_op(F_ALLOC, idx, ver, key);
      else if (pick < 60) queue_op(F_RELEASE, idx, ver, key);
      else if (pick < 80) queue_op(F_VALIDATE, idx, ver, key);
      else queue_op(F_FIND, idx, ver, key);
    end
    quiet = 1'b0;

    // Release the newest slot twice, so it sits twice on the free list, then reuse it.
    drain();
    idx = IDX_W'(used_cnt - 1);
    ver = slot_ver[idx];
    queue_op(F_VALIDATE, idx, ver, '0);
    queue_op(F_RELEASE, idx, ver, '0);
    queue_op(F_RELEASE, idx, ver + 1'b1, '0);
    queue_op(F_VALIDATE, idx, ver, '0);
    queue_op(F_ALLOC, '0, '0, 32'hDEAD_0001);
    queue_op(F_FIND, '0, '0, 32'hDEAD_0001);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
